// ===== rtl/midi_tep_pkg.sv =====
// ----------------------------------------------------------------------------
// midi_tep_pkg: shared types and constants of the midi track event parser
// per-track context layout, event record, command, kind and parse phase codes
// ----------------------------------------------------------------------------
package midi_tep_pkg;

   localparam int TRACK_BITS  = 4;
   localparam int TICK_BITS   = 48;
   localparam int ACC_BITS    = 32;
   localparam int GATHER_BITS = 24;

   // status and meta codes
   localparam logic [7:0] ST_META    = 8'hFF;
   localparam logic [7:0] ST_SYSEX   = 8'hF0;
   localparam logic [7:0] ST_ESCAPE  = 8'hF7;
   localparam logic [7:0] META_END   = 8'h2F;
   localparam logic [7:0] META_TEMPO = 8'h51;
   localparam logic [7:0] META_TSIG  = 8'h58;
   localparam logic [3:0] HI_NOTE_OFF = 4'h8;
   localparam logic [3:0] HI_NOTE_ON  = 4'h9;
   localparam logic [3:0] HI_PROGRAM  = 4'hC;
   localparam logic [3:0] HI_PRESSURE = 4'hD;
   localparam logic [3:0] HI_SYSTEM   = 4'hF;
   localparam logic [ACC_BITS-1:0] TEMPO_LEN = ACC_BITS'(3);
   localparam logic [ACC_BITS-1:0] TSIG_LEN  = ACC_BITS'(4);
   localparam logic [ACC_BITS-1:0] TSIG_GATHER_MIN = ACC_BITS'(2);

   typedef enum logic [1:0] {
      CMD_DATA      = 2'd0,
      CMD_RESTART   = 2'd1,
      CMD_CHUNK_END = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_ON    = 3'd1,
      KIND_OFF   = 3'd2,
      KIND_TEMPO = 3'd3,
      KIND_TSIG  = 3'd4,
      KIND_END   = 3'd5
   } kind_type;

   typedef enum logic [9:0] {
      PH_DELTA     = 10'b00_0000_0001,
      PH_STATUS    = 10'b00_0000_0010,
      PH_DATA1     = 10'b00_0000_0100,
      PH_DATA2     = 10'b00_0000_1000,
      PH_SINGLE    = 10'b00_0001_0000,
      PH_META_TYPE = 10'b00_0010_0000,
      PH_META_LEN  = 10'b00_0100_0000,
      PH_META_BODY = 10'b00_1000_0000,
      PH_SYX_LEN   = 10'b01_0000_0000,
      PH_SYX_BODY  = 10'b10_0000_0000
   } phase_type;

   typedef struct packed {
      logic [TICK_BITS-1:0]   tick_total;
      logic [ACC_BITS-1:0]    delta_acc;
      logic [7:0]             last_status;
      logic                   done;
      phase_type              phase;
      logic [7:0]             meta_kind;
      logic [ACC_BITS-1:0]    remaining;
      logic [GATHER_BITS-1:0] gather;
   } ctx_type;

   localparam ctx_type CTX_RESET = '{
      tick_total:  '0,
      delta_acc:   '0,
      last_status: '0,
      done:        1'b0,
      phase:       PH_DELTA,
      meta_kind:   '0,
      remaining:   '0,
      gather:      '0
   };

   typedef struct packed {
      logic [TRACK_BITS-1:0] track;
      kind_type              kind;
      logic [3:0]            channel;
      logic [7:0]            note;
      logic [7:0]            velocity;
      logic [23:0]           tempo;
      logic [7:0]            numerator;
      logic [7:0]            denominator;
      logic [TICK_BITS-1:0]  ticks;
   } event_type;

   // channel nibble for 0x80..0xEF status, else zero
   function automatic logic [3:0] chan_of(input logic [7:0] st);
      return (st[7] && (st[7:4] != HI_SYSTEM)) ? st[3:0] : 4'h0;
   endfunction

endpackage

// ===== rtl/midi_tep_step.sv =====
// ----------------------------------------------------------------------------
// midi_tep_step: one byte of context update for one track
// takes a track context and one command, gives the new context and an event
// ----------------------------------------------------------------------------
module midi_tep_step
   import midi_tep_pkg::*;
(
   input  cmd_type               cmd,
   input  logic [TRACK_BITS-1:0] track,
   input  logic [7:0]            data_byte,
   input  ctx_type               ctx,
   output ctx_type               ctx_next,
   output logic                  wr_en,
   output logic                  ev_valid,
   output event_type             ev
);

   logic [3:0]            hi;
   logic [ACC_BITS-1:0]   len_shift;
   logic [ACC_BITS-1:0]   len_dec;
   logic [ACC_BITS-1:0]   delta_shift;
   logic [7:0]            meta_keep;
   logic [GATHER_BITS-1:0] body_gather;

   always_comb begin
      hi          = ctx.last_status[7:4];
      len_shift   = {ctx.remaining[ACC_BITS-8:0], data_byte[6:0]};
      len_dec     = ctx.remaining - ACC_BITS'(1);
      delta_shift = {ctx.delta_acc[ACC_BITS-8:0], data_byte[6:0]};
      meta_keep   = (((ctx.meta_kind == META_TEMPO) && (len_shift == TEMPO_LEN)) ||
                     ((ctx.meta_kind == META_TSIG) && (len_shift == TSIG_LEN)))
                    ? ctx.meta_kind : 8'h00;
      body_gather = ctx.gather;
      if ((ctx.meta_kind == META_TEMPO) ||
          ((ctx.meta_kind == META_TSIG) && (ctx.remaining > TSIG_GATHER_MIN))) begin
         body_gather = {ctx.gather[GATHER_BITS-9:0], data_byte};
      end

      ctx_next = ctx;
      wr_en    = 1'b1;
      ev_valid = 1'b0;
      ev       = '0;
      ev.track = track;
      ev.kind  = KIND_NONE;
      ev.ticks = ctx.tick_total;

      case (cmd)
         CMD_RESTART: begin
            ctx_next = CTX_RESET;
         end
         CMD_CHUNK_END: begin
            if (!ctx.done) begin
               ctx_next.done      = 1'b1;
               ctx_next.phase     = PH_DELTA;
               ctx_next.delta_acc = '0;
               ctx_next.remaining = '0;
               ctx_next.gather    = '0;
               ctx_next.meta_kind = '0;
               ev_valid           = 1'b1;
               ev.kind            = KIND_END;
            end
         end
         CMD_DATA: begin
            if (!ctx.done) begin
               case (ctx.phase)
                  PH_STATUS: begin
                     if (data_byte[7]) begin
                        if (data_byte == ST_META) begin
                           ctx_next.last_status = '0;
                           ctx_next.phase       = PH_META_TYPE;
                        end else if (data_byte == ST_SYSEX || data_byte == ST_ESCAPE) begin
                           ctx_next.last_status = '0;
                           ctx_next.remaining   = '0;
                           ctx_next.phase       = PH_SYX_LEN;
                        end else if (data_byte[7:4] == HI_SYSTEM) begin
                           ctx_next.last_status = '0;
                           ctx_next.phase       = PH_DATA1;
                        end else begin
                           ctx_next.last_status = data_byte;
                           ctx_next.phase = (data_byte[7:4] == HI_PROGRAM ||
                                             data_byte[7:4] == HI_PRESSURE)
                                            ? PH_SINGLE : PH_DATA1;
                        end
                     end else if (hi == HI_PROGRAM || hi == HI_PRESSURE) begin
                        // running status, one data byte
                        ctx_next.phase = PH_DELTA;
                        ev_valid       = 1'b1;
                        ev.channel     = chan_of(ctx.last_status);
                     end else begin
                        ctx_next.gather = GATHER_BITS'(data_byte);
                        ctx_next.phase  = PH_DATA2;
                     end
                  end
                  PH_DATA1: begin
                     ctx_next.gather = GATHER_BITS'(data_byte);
                     ctx_next.phase  = PH_DATA2;
                  end
                  PH_DATA2: begin
                     ctx_next.phase  = PH_DELTA;
                     ctx_next.gather = '0;
                     ev_valid        = 1'b1;
                     ev.channel      = chan_of(ctx.last_status);
                     if (hi == HI_NOTE_ON || hi == HI_NOTE_OFF) begin
                        // note on with zero velocity reads as note off
                        ev.kind     = (hi == HI_NOTE_ON && data_byte != 8'h00)
                                      ? KIND_ON : KIND_OFF;
                        ev.note     = ctx.gather[7:0];
                        ev.velocity = data_byte;
                     end
                  end
                  PH_SINGLE: begin
                     ctx_next.phase = PH_DELTA;
                     ev_valid       = 1'b1;
                     ev.channel     = chan_of(ctx.last_status);
                  end
                  PH_META_TYPE: begin
                     ctx_next.meta_kind = data_byte;
                     ctx_next.remaining = '0;
                     ctx_next.phase     = PH_META_LEN;
                  end
                  PH_META_LEN: begin
                     ctx_next.remaining = len_shift;
                     if (!data_byte[7]) begin
                        if (ctx.meta_kind == META_END) begin
                           ctx_next.done  = 1'b1;
                           ctx_next.phase = PH_DELTA;
                           ev_valid       = 1'b1;
                           ev.kind        = KIND_END;
                        end else begin
                           ctx_next.meta_kind = meta_keep;
                           ctx_next.gather    = '0;
                           if (len_shift == '0) begin
                              // empty body, kept kind is always cleared here
                              ctx_next.phase = PH_DELTA;
                              ev_valid       = 1'b1;
                           end else begin
                              ctx_next.phase = PH_META_BODY;
                           end
                        end
                     end
                  end
                  PH_META_BODY: begin
                     ctx_next.remaining = len_dec;
                     ctx_next.gather    = body_gather;
                     if (len_dec == '0) begin
                        ctx_next.phase  = PH_DELTA;
                        ctx_next.gather = '0;
                        ev_valid        = 1'b1;
                        if (ctx.meta_kind == META_TEMPO) begin
                           ev.kind  = KIND_TEMPO;
                           ev.tempo = body_gather;
                        end else if (ctx.meta_kind == META_TSIG) begin
                           ev.kind        = KIND_TSIG;
                           ev.numerator   = body_gather[15:8];
                           ev.denominator = body_gather[7:0];
                        end
                     end
                  end
                  PH_SYX_LEN: begin
                     ctx_next.remaining = len_shift;
                     if (!data_byte[7]) begin
                        if (len_shift == '0) begin
                           ctx_next.phase = PH_DELTA;
                           ev_valid       = 1'b1;
                        end else begin
                           ctx_next.phase = PH_SYX_BODY;
                        end
                     end
                  end
                  PH_SYX_BODY: begin
                     ctx_next.remaining = len_dec;
                     if (len_dec == '0) begin
                        ctx_next.phase = PH_DELTA;
                        ev_valid       = 1'b1;
                     end
                  end
                  default: begin
                     // delta time byte
                     if (data_byte[7]) begin
                        ctx_next.delta_acc = delta_shift;
                        ctx_next.phase     = PH_DELTA;
                     end else begin
                        ctx_next.tick_total = ctx.tick_total + TICK_BITS'(delta_shift);
                        ctx_next.delta_acc  = '0;
                        ctx_next.phase      = PH_STATUS;
                     end
                  end
               endcase
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/midi_track_event_parser.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_parser: per-track midi file event decoder
// bytes of up to sixteen interleaved track chunks in, decoded events out
// ----------------------------------------------------------------------------
// One request transaction is taken per cycle while the decode stage is not
// stalled, and each carries one byte (or a restart or chunk-end command) for one
// track. Every track keeps its own context (absolute ticks, pending delta,
// running status, parse phase, meta length and payload) in a 16-entry context
// memory. A transaction reads its track's context on acceptance; the decode
// stage then decodes it, writes it back and loads its response into the
// response register, so throughput is one transaction per cycle while that
// register is not held; the last written result is forwarded when the same track
// comes back to back. A transaction makes at most one response: note on/off,
// tempo, time signature, end, or kind none for skipped messages. Responses sit in
// an output register; while it is held by rsp_tready low, requests that make no
// response still flow, and a request that makes one waits. No clearing pass is
// needed after reset: each context entry has a valid flag and reads as the reset context until first written.
// ----------------------------------------------------------------------------
module midi_track_event_parser
   import midi_tep_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,  // [3:0] track, [11:4] data_byte, [15:12] zero
   input  logic [1:0]   req_tuser,  // [1:0] command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,  // [3:0] event_track, [7:4] channel,
                                    // [15:8] note_number, [23:16] note_velocity,
                                    // [47:24] tempo_microseconds,
                                    // [55:48] signature_numerator,
                                    // [63:56] signature_denominator_power,
                                    // [111:64] absolute_ticks
   output logic [2:0]   rsp_tuser   // [2:0] event_kind
);

   localparam int DEPTH = 2 ** TRACK_BITS;

   // context memory and its per-entry valid flags
   ctx_type           ctx_mem [DEPTH];
   logic [DEPTH-1:0]  entry_valid_ff;

   // decode stage
   logic                  s1_valid_ff;
   cmd_type               s1_cmd_ff;
   logic [TRACK_BITS-1:0] s1_track_ff;
   logic [7:0]            s1_byte_ff;
   ctx_type               rd_ctx_ff;
   logic                  rd_valid_ff;

   // last write to the context memory, for back-to-back same-track hits
   logic                  fwd_valid_ff;
   logic [TRACK_BITS-1:0] fwd_track_ff;
   ctx_type               fwd_ctx_ff;

   // response register
   logic      rsp_valid_ff;
   event_type rsp_ev_ff;

   ctx_type   cur_ctx;
   ctx_type   ctx_next;
   logic      wr_en;
   logic      ev_valid;
   event_type ev;
   logic      req_fire;
   logic      s1_fire;
   logic      wr_fire;

   assign s1_fire    = s1_valid_ff && (!ev_valid || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign wr_fire    = s1_fire && wr_en;

   // newest copy of this track's context
   always_comb begin
      if (fwd_valid_ff && (fwd_track_ff == s1_track_ff)) begin
         cur_ctx = fwd_ctx_ff;
      end else if (rd_valid_ff) begin
         cur_ctx = rd_ctx_ff;
      end else begin
         cur_ctx = CTX_RESET;
      end
   end

   midi_tep_step u_step (
      .cmd       (s1_cmd_ff),
      .track     (s1_track_ff),
      .data_byte (s1_byte_ff),
      .ctx       (cur_ctx),
      .ctx_next  (ctx_next),
      .wr_en     (wr_en),
      .ev_valid  (ev_valid),
      .ev        (ev)
   );

   // memory read on acceptance, write back after decode
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ctx_ff <= ctx_mem[req_tdata[TRACK_BITS-1:0]];
      end
      if (wr_fire) begin
         ctx_mem[s1_track_ff] <= ctx_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (req_fire) begin
            rd_valid_ff <= entry_valid_ff[req_tdata[TRACK_BITS-1:0]];
         end
         if (wr_fire) begin
            entry_valid_ff[s1_track_ff] <= 1'b1;
         end
      end
   end

   // decode stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff   <= cmd_type'(req_tuser);
         s1_track_ff <= req_tdata[TRACK_BITS-1:0];
         s1_byte_ff  <= req_tdata[11:4];
      end
   end

   // forwarding register always holds the latest write of its track
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (wr_fire) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         fwd_track_ff <= s1_track_ff;
         fwd_ctx_ff   <= ctx_next;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && ev_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && ev_valid) begin
         rsp_ev_ff <= ev;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ev_ff.kind;
   assign rsp_tdata  = {rsp_ev_ff.ticks, rsp_ev_ff.denominator, rsp_ev_ff.numerator,
                        rsp_ev_ff.tempo, rsp_ev_ff.velocity, rsp_ev_ff.note,
                        rsp_ev_ff.channel, rsp_ev_ff.track};

   // a new response only comes out of a decode in the cycle before
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("response loaded without a decoded transaction");

   // note fields are zero unless the event is a note
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ev_ff.kind != KIND_ON) && (rsp_ev_ff.kind != KIND_OFF)
      |-> (rsp_ev_ff.note == 8'h00) && (rsp_ev_ff.velocity == 8'h00))
      else $error("note fields set on a non-note event");

   // a written track is marked valid from the next cycle on
   assert property (@(posedge clock) disable iff (reset)
      wr_fire |=> entry_valid_ff[fwd_track_ff] && fwd_valid_ff)
      else $error("context write not recorded");

   // end events carry no channel, tempo or signature
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ev_ff.kind == KIND_END)
      |-> (rsp_ev_ff.channel == 4'h0) && (rsp_ev_ff.tempo == 24'h0)
          && (rsp_ev_ff.numerator == 8'h00))
      else $error("end event with payload");

endmodule
